>>> src/ahre_pkg.sv
// Shared types and constants for the attack/hold/release envelope block.
// No dependencies.
package ahre_pkg;

  localparam int CHANNEL_BITS_DEF = 16;
  localparam int TIME_BITS_DEF    = 32;
  localparam int LEN_BITS         = 16;
  localparam int STAMP_BITS       = 32;
  localparam int CFG_IDX_BITS     = 3;
  localparam int CFG_DATA_BITS    = 32;
  localparam int QUEUE_DEPTH      = 2;

  typedef enum logic [CFG_IDX_BITS-1:0] {
    REG_START   = 3'd0,
    REG_ATTACK  = 3'd1,
    REG_HOLD    = 3'd2,
    REG_RELEASE = 3'd3,
    REG_SLEEP   = 3'd4
  } cfg_reg_e;

  typedef enum logic [2:0] {
    PH_BEFORE  = 3'd0,
    PH_ATTACK  = 3'd1,
    PH_HOLD    = 3'd2,
    PH_RELEASE = 3'd3,
    PH_DONE    = 3'd4
  } phase_e;

  // Scale job: result = floor(c * num / den); num < den or num == den == 1.
  typedef struct packed {
    logic [LEN_BITS-1:0] num;
    logic [LEN_BITS-1:0] den;
    phase_e              phase;
    logic                expired;
  } ahre_job_t;

endpackage

>>> src/ahre_if.sv
// Channel interfaces: input beats, result beats and config writes.
// Depends on ahre_pkg.
interface ahre_in_if import ahre_pkg::*; #(parameter int CHANNEL_BITS = CHANNEL_BITS_DEF);
  logic                    valid;
  logic                    ready;
  logic [STAMP_BITS-1:0]   now_stamp;
  logic [CHANNEL_BITS-1:0] ref_red;
  logic [CHANNEL_BITS-1:0] ref_green;
  logic [CHANNEL_BITS-1:0] ref_blue;
  modport source (output valid, now_stamp, ref_red, ref_green, ref_blue, input ready);
  modport sink   (input valid, now_stamp, ref_red, ref_green, ref_blue, output ready);
endinterface

interface ahre_out_if import ahre_pkg::*; #(parameter int CHANNEL_BITS = CHANNEL_BITS_DEF);
  logic                    valid;
  logic                    ready;
  logic [CHANNEL_BITS-1:0] out_red;
  logic [CHANNEL_BITS-1:0] out_green;
  logic [CHANNEL_BITS-1:0] out_blue;
  logic [2:0]              phase;
  logic                    expired;
  modport source (output valid, out_red, out_green, out_blue, phase, expired, input ready);
  modport sink   (input valid, out_red, out_green, out_blue, phase, expired, output ready);
endinterface

interface ahre_cfg_if import ahre_pkg::*;;
  logic                     valid;
  logic                     ready;
  logic [CFG_IDX_BITS-1:0]  index;
  logic [CFG_DATA_BITS-1:0] data;
  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

>>> src/ahre_front.sv
// Front end: config registers and per-beat phase classification.
// Depends on ahre_pkg.
module ahre_front import ahre_pkg::*; #(
  parameter int TIME_BITS = TIME_BITS_DEF
) (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     cfg_we_i,
  input  logic [CFG_IDX_BITS-1:0]  cfg_idx_i,
  input  logic [CFG_DATA_BITS-1:0] cfg_data_i,
  input  logic [STAMP_BITS-1:0]    now_i,
  output ahre_job_t                job_o
);
  localparam int CW = (TIME_BITS > 19) ? TIME_BITS : 19;

  logic [TIME_BITS-1:0] start_q;
  logic [LEN_BITS-1:0]  att_q, hold_q, rel_q, slp_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      start_q <= '0;
      att_q   <= '0;
      hold_q  <= '0;
      rel_q   <= '0;
      slp_q   <= '0;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        REG_START:   start_q <= TIME_BITS'(cfg_data_i);
        REG_ATTACK:  att_q   <= cfg_data_i[LEN_BITS-1:0];
        REG_HOLD:    hold_q  <= cfg_data_i[LEN_BITS-1:0];
        REG_RELEASE: rel_q   <= cfg_data_i[LEN_BITS-1:0];
        REG_SLEEP:   slp_q   <= cfg_data_i[LEN_BITS-1:0];
        default: ;
      endcase
    end
  end

  logic [TIME_BITS-1:0] d, e;
  logic [CW-1:0]        dw, ah, ahr, total;
  logic                 pos;

  always_comb begin
    d     = TIME_BITS'(now_i) - start_q;
    dw    = CW'(d);
    ah    = CW'(att_q) + CW'(hold_q);
    ahr   = ah + CW'(rel_q);
    total = ahr + CW'(slp_q);
    e     = d - TIME_BITS'(total);
    pos   = (d != '0) && !d[TIME_BITS-1];

    job_o.expired = (e != '0) && !e[TIME_BITS-1];
    // black and pass-through both reduce to num/den of 0/1 and 1/1
    job_o.num = '0;
    job_o.den = LEN_BITS'(1);
    if (!pos) begin
      job_o.phase = PH_BEFORE;
    end else if (dw < CW'(att_q)) begin
      job_o.phase = PH_ATTACK;
      job_o.num   = dw[LEN_BITS-1:0];
      job_o.den   = att_q;
    end else if (dw <= ah) begin
      job_o.phase = PH_HOLD;
      job_o.num   = LEN_BITS'(1);
    end else if (dw < ahr) begin
      job_o.phase = PH_RELEASE;
      job_o.num   = LEN_BITS'(ahr - dw);  // release - (d - attack - hold)
      job_o.den   = rel_q;
    end else begin
      job_o.phase = PH_DONE;
    end
  end
endmodule

>>> src/ahre_queue.sv
// Short FIFO between classifier and scaling pipeline.
// Depends on ahre_pkg.
module ahre_queue import ahre_pkg::*; #(
  parameter int CHANNEL_BITS = CHANNEL_BITS_DEF,
  parameter int DEPTH        = QUEUE_DEPTH
) (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    push_i,
  input  ahre_job_t               job_i,
  input  logic [CHANNEL_BITS-1:0] col_i [3],
  output logic                    full_o,
  input  logic                    pop_i,
  output logic                    empty_o,
  output ahre_job_t               job_o,
  output logic [CHANNEL_BITS-1:0] col_o [3]
);
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

  ahre_job_t               job_mem [DEPTH];
  logic [CHANNEL_BITS-1:0] col_mem [DEPTH][3];
  logic [AW-1:0]           wp_q, rp_q;
  logic [AW:0]             cnt_q;

  assign full_o  = (cnt_q == (AW+1)'(DEPTH));
  assign empty_o = (cnt_q == '0);
  assign job_o   = job_mem[rp_q];
  assign col_o   = col_mem[rp_q];

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      job_mem[wp_q] <= job_i;
      col_mem[wp_q] <= col_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wp_q  <= '0;
      rp_q  <= '0;
      cnt_q <= '0;
    end else begin
      if (push_i) wp_q <= (wp_q == AW'(DEPTH-1)) ? '0 : wp_q + 1'b1;
      if (pop_i)  rp_q <= (rp_q == AW'(DEPTH-1)) ? '0 : rp_q + 1'b1;
      cnt_q <= cnt_q + (AW+1)'(push_i) - (AW+1)'(pop_i);
    end
  end
endmodule

>>> src/ahre_back.sv
// Back end: multiply then bit-per-stage restoring divide, three channels.
// Depends on ahre_pkg.
module ahre_back import ahre_pkg::*; #(
  parameter int CHANNEL_BITS = CHANNEL_BITS_DEF
) (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    empty_i,
  input  ahre_job_t               job_i,
  input  logic [CHANNEL_BITS-1:0] col_i [3],
  output logic                    pop_o,
  output logic                    out_valid_o,
  input  logic                    out_ready_i,
  output logic [CHANNEL_BITS-1:0] res_o [3],
  output ahre_job_t               job_o
);
  localparam int NS = CHANNEL_BITS + 1;  // product stage + one per quotient bit
  localparam int PW = CHANNEL_BITS + LEN_BITS;

  logic                    vld_q [NS];
  ahre_job_t               job_q [NS];
  logic [LEN_BITS-1:0]     rem_q [NS][3];
  logic [CHANNEL_BITS-1:0] low_q [NS][3];  // dividend bits out, quotient bits in
  logic                    adv;
  logic [PW-1:0]           prod [3];

  assign adv         = !vld_q[NS-1] || out_ready_i;
  assign pop_o       = adv && !empty_i;
  assign out_valid_o = vld_q[NS-1];
  assign job_o       = job_q[NS-1];
  assign res_o       = low_q[NS-1];

  always_comb begin
    for (int c = 0; c < 3; c++) prod[c] = PW'(col_i[c]) * PW'(job_i.num);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int s = 0; s < NS; s++) vld_q[s] <= 1'b0;
    end else if (adv) begin
      vld_q[0] <= !empty_i;
      for (int s = 1; s < NS; s++) vld_q[s] <= vld_q[s-1];
    end
  end

  always_ff @(posedge clk_i) begin
    logic [LEN_BITS:0] t;
    if (adv) begin
      job_q[0] <= job_i;
      for (int c = 0; c < 3; c++) begin
        rem_q[0][c] <= prod[c][PW-1:CHANNEL_BITS];
        low_q[0][c] <= prod[c][CHANNEL_BITS-1:0];
      end
      for (int s = 1; s < NS; s++) begin
        job_q[s] <= job_q[s-1];
        for (int c = 0; c < 3; c++) begin
          t = {rem_q[s-1][c], low_q[s-1][c][CHANNEL_BITS-1]};
          if (t >= {1'b0, job_q[s-1].den}) begin
            rem_q[s][c] <= LEN_BITS'(t - {1'b0, job_q[s-1].den});
            low_q[s][c] <= {low_q[s-1][c][CHANNEL_BITS-2:0], 1'b1};
          end else begin
            rem_q[s][c] <= t[LEN_BITS-1:0];
            low_q[s][c] <= {low_q[s-1][c][CHANNEL_BITS-2:0], 1'b0};
          end
        end
      end
    end
  end

  // initial partial remainder in stage 0 stays below the divisor
  a_rem_lt_den: assert property (@(posedge clk_i) disable iff (!rst_ni)
    vld_q[0] |-> (rem_q[0][0] < job_q[0].den) && (rem_q[0][1] < job_q[0].den)
                 && (rem_q[0][2] < job_q[0].den))
    else $error("remainder not below divisor");

  // dark phases give black
  a_dark: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (job_o.phase == PH_BEFORE || job_o.phase == PH_DONE)
    |-> (res_o[0] == '0) && (res_o[1] == '0) && (res_o[2] == '0))
    else $error("dark phase with nonzero color");

  // a stalled result is not overwritten by the pipeline
  a_stall_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(res_o[0]) && $stable(job_o))
    else $error("stalled result changed");
endmodule

>>> src/attack_hold_release_envelope.sv
// Top level of the attack/hold/release envelope block.
// Depends on ahre_pkg, ahre_if, ahre_front, ahre_queue, ahre_back.
//
//  channel | dir | payload                                 | accepted when
//  in_i    | in  | now_stamp, ref_red/green/blue           | valid & ready
//  out_o   | out | out_red/green/blue, phase, expired      | valid & ready
//  cfg_i   | in  | index (0 start..4 sleep), data          | valid & ready
//
// Throughput one beat per cycle while the output is not stalled; a beat passes
// through the queue, the product stage, then one restoring-divide stage per quotient bit.
// Reset clears config registers, queue pointers and pipeline valids.
// A stalled output freezes the scaling pipe; the two-entry queue keeps
// taking beats until full. cfg_i is always ready.
module attack_hold_release_envelope import ahre_pkg::*; #(
  parameter int CHANNEL_BITS = CHANNEL_BITS_DEF,
  parameter int TIME_BITS    = TIME_BITS_DEF
) (
  input  logic clk_i,
  input  logic rst_ni,
  ahre_in_if.sink   in_i,
  ahre_out_if.source out_o,
  ahre_cfg_if.sink  cfg_i
);
  ahre_job_t               f_job, q_job, b_job;
  logic [CHANNEL_BITS-1:0] f_col [3];
  logic [CHANNEL_BITS-1:0] q_col [3];
  logic [CHANNEL_BITS-1:0] b_res [3];
  logic                    q_full, q_empty, q_pop;

  assign cfg_i.ready = 1'b1;
  assign in_i.ready  = !q_full;
  assign f_col[0]    = in_i.ref_red;
  assign f_col[1]    = in_i.ref_green;
  assign f_col[2]    = in_i.ref_blue;

  ahre_front #(.TIME_BITS(TIME_BITS)) u_front (
    .clk_i, .rst_ni,
    .cfg_we_i   (cfg_i.valid),
    .cfg_idx_i  (cfg_i.index),
    .cfg_data_i (cfg_i.data),
    .now_i      (in_i.now_stamp),
    .job_o      (f_job)
  );

  ahre_queue #(.CHANNEL_BITS(CHANNEL_BITS)) u_queue (
    .clk_i, .rst_ni,
    .push_i  (in_i.valid && !q_full),
    .job_i   (f_job),
    .col_i   (f_col),
    .full_o  (q_full),
    .pop_i   (q_pop),
    .empty_o (q_empty),
    .job_o   (q_job),
    .col_o   (q_col)
  );

  ahre_back #(.CHANNEL_BITS(CHANNEL_BITS)) u_back (
    .clk_i, .rst_ni,
    .empty_i     (q_empty),
    .job_i       (q_job),
    .col_i       (q_col),
    .pop_o       (q_pop),
    .out_valid_o (out_o.valid),
    .out_ready_i (out_o.ready),
    .res_o       (b_res),
    .job_o       (b_job)
  );

  assign out_o.out_red   = b_res[0];
  assign out_o.out_green = b_res[1];
  assign out_o.out_blue  = b_res[2];
  assign out_o.phase     = b_job.phase;
  assign out_o.expired   = b_job.expired;
endmodule

>>> tb/ahre_checker.sv
// Envelope checker: watches config writes, input beats and result beats,
// predicts each result and compares it field by field. Depends on ahre_pkg, ahre_if.
module ahre_checker import ahre_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  ahre_in_if.sink    in_m,
  ahre_out_if.sink   out_m,
  ahre_cfg_if.sink   cfg_m,
  output int         fail_cnt_o,
  output int         pending_o
);
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct packed {
    logic [15:0] red;
    logic [15:0] green;
    logic [15:0] blue;
    phase_e      phase;
    logic        expired;
  } env_res_t;

  logic [31:0] start_q;
  logic [15:0] att_q, hold_q, rel_q, sleep_q;
  env_res_t    exp_q[$];

  function automatic logic [15:0] scale(logic [15:0] c, logic [31:0] num, logic [31:0] den);
    logic [63:0] p;
    p = {48'd0, c} * {32'd0, num};
    return 16'(p / {32'd0, den});
  endfunction

  function automatic env_res_t envelope(logic [31:0] now, logic [15:0] r, logic [15:0] g,
                                        logic [15:0] b);
    env_res_t    e;
    logic [31:0] d, ah, ahr, total, x, left;
    d     = now - start_q;
    ah    = 32'(att_q) + 32'(hold_q);
    ahr   = ah + 32'(rel_q);
    total = ahr + 32'(sleep_q);
    e     = '0;
    if (d == 0 || d[31]) begin
      e.phase = PH_BEFORE;
    end else if (d < 32'(att_q)) begin
      e.phase = PH_ATTACK;
      e.red = scale(r, d, 32'(att_q));
      e.green = scale(g, d, 32'(att_q));
      e.blue = scale(b, d, 32'(att_q));
    end else if (d <= ah) begin
      e.phase = PH_HOLD;
      e.red = r; e.green = g; e.blue = b;
    end else if (d < ahr) begin
      e.phase = PH_RELEASE;
      left = 32'(rel_q) - (d - ah);
      e.red = scale(r, left, 32'(rel_q));
      e.green = scale(g, left, 32'(rel_q));
      e.blue = scale(b, left, 32'(rel_q));
    end else begin
      e.phase = PH_DONE;
    end
    x = now - start_q - total;
    e.expired = (x != 0) && !x[31];
    return e;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    env_res_t e;
    if (!rst_ni) begin
      start_q <= '0; att_q <= '0; hold_q <= '0; rel_q <= '0; sleep_q <= '0;
      fail_cnt_o <= 0;
      pending_o <= 0;
      exp_q.delete();
    end else begin
      if (cfg_m.valid && cfg_m.ready) begin
        case (cfg_m.index)
          REG_START:   start_q <= cfg_m.data;
          REG_ATTACK:  att_q   <= cfg_m.data[15:0];
          REG_HOLD:    hold_q  <= cfg_m.data[15:0];
          REG_RELEASE: rel_q   <= cfg_m.data[15:0];
          REG_SLEEP:   sleep_q <= cfg_m.data[15:0];
          default: ;
        endcase
      end
      if (in_m.valid && in_m.ready)
        exp_q.insert(exp_q.size(), envelope(in_m.now_stamp, in_m.ref_red, in_m.ref_green,
                                            in_m.ref_blue));
      if (out_m.valid && out_m.ready) begin
        if (exp_q.size() == 0) begin
          $display("%0t: result beat with nothing expected: got %h %h %h ph %0d exp %b",
                   $time, out_m.out_red, out_m.out_green, out_m.out_blue,
                   out_m.phase, out_m.expired);
          fail_cnt_o <= fail_cnt_o + 1;
        end else begin
          e = exp_q.pop_front();
          if (out_m.out_red !== e.red || out_m.out_green !== e.green ||
              out_m.out_blue !== e.blue || out_m.phase !== 3'(e.phase) ||
              out_m.expired !== e.expired) begin
            $display("%0t: mismatch exp %h %h %h ph %0d exp %b, got %h %h %h ph %0d exp %b",
                     $time, e.red, e.green, e.blue, e.phase, e.expired,
                     out_m.out_red, out_m.out_green, out_m.out_blue,
                     out_m.phase, out_m.expired);
            fail_cnt_o <= fail_cnt_o + 1;
          end
        end
      end
      pending_o <= exp_q.size();
    end
  end
endmodule

>>> tb/attack_hold_release_envelope_tb.sv
// Testbench top: drives config, input beats and output backpressure for the
// envelope block; checking lives in ahre_checker. Depends on ahre_pkg, ahre_if.
module attack_hold_release_envelope_tb import ahre_pkg::*;;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int WATCHDOG = 20000;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  int   fail_cnt, pending;
  int   idle_pct_in = 18, idle_pct_out = 18;
  bit   hold_off = 1'b0;   // long receiver stall to fill the queue
  int   quiet = 0;         // cycles without any accepted beat

  ahre_in_if  in_ch();
  ahre_out_if out_ch();
  ahre_cfg_if cfg_ch();

  attack_hold_release_envelope uut (
    .clk_i(clk_i), .rst_ni(rst_ni), .in_i(in_ch), .out_o(out_ch), .cfg_i(cfg_ch)
  );

  ahre_checker chk (
    .clk_i(clk_i), .rst_ni(rst_ni), .in_m(in_ch), .out_m(out_ch), .cfg_m(cfg_ch),
    .fail_cnt_o(fail_cnt), .pending_o(pending)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // Receiver: random stalls, plus a held-off stretch on request.
  always @(negedge clk_i) begin
    out_ch.ready <= !hold_off && ($urandom_range(99) >= idle_pct_out);
  end

  // Watchdog on acceptance activity.
  always @(posedge clk_i) begin
    if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready) ||
        (cfg_ch.valid && cfg_ch.ready))
      quiet <= 0;
    else
      quiet <= quiet + 1;
    if (quiet > WATCHDOG) begin
      $display("[attack_hold_release_envelope] ERROR");
      $finish;
    end
  end

  task automatic write_reg(cfg_reg_e idx, logic [31:0] val);
    cfg_ch.index <= idx;
    cfg_ch.data  <= val;
    cfg_ch.valid <= 1'b1;
    do @(posedge clk_i); while (!cfg_ch.ready);
    @(negedge clk_i);
    cfg_ch.valid <= 1'b0;
  endtask

  task automatic set_envelope(logic [31:0] st, logic [15:0] a, logic [15:0] h,
                              logic [15:0] r, logic [15:0] s);
    write_reg(REG_START, st);
    write_reg(REG_ATTACK, {16'($urandom_range(65535)), a}); // upper bits are masked
    write_reg(REG_HOLD, 32'(h));
    write_reg(REG_RELEASE, 32'(r));
    write_reg(REG_SLEEP, 32'(s));
  endtask

  // One input beat; a random gap first so idles land on every pipe phase.
  task automatic send_beat(logic [31:0] now, logic [15:0] r, logic [15:0] g,
                           logic [15:0] b);
    while ($urandom_range(99) < idle_pct_in) begin
      in_ch.valid <= 1'b0;
      @(negedge clk_i);
    end
    in_ch.valid     <= 1'b1;
    in_ch.now_stamp <= now;
    in_ch.ref_red   <= r;
    in_ch.ref_green <= g;
    in_ch.ref_blue  <= b;
    do @(posedge clk_i); while (!in_ch.ready);
    @(negedge clk_i);
  endtask

  // Wait for all results, then let the pipe drain before touching config.
  task automatic drain();
    in_ch.valid <= 1'b0;
    while (pending != 0) @(negedge clk_i);
    repeat (24) @(negedge clk_i);
  endtask

  function automatic logic [15:0] rnd_chan();
    case ($urandom_range(3))
      0: return 16'h0000;
      1: return 16'hFFFF;
      default: return 16'($urandom);
    endcase
  endfunction

  // Time stamp aimed near phase boundaries of the current envelope.
  function automatic logic [31:0] rnd_now(logic [31:0] st, int span);
    case ($urandom_range(9))
      0: return $urandom;
      1: return st + 32'h8000_0000 + $urandom_range(2) - 1;   // sign flip of d
      default: return st + $urandom_range(span + 4) - 2;
    endcase
  endfunction

  initial begin
    logic [31:0] st;
    int a, h, r, s;
    in_ch.valid = 1'b0; in_ch.now_stamp = '0;
    in_ch.ref_red = '0; in_ch.ref_green = '0; in_ch.ref_blue = '0;
    cfg_ch.valid = 1'b0; cfg_ch.index = REG_START; cfg_ch.data = '0;
    repeat (11) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // Directed: reset config (zero attack and release), then a typical envelope.
    send_beat(32'd0, 16'hFFFF, 16'hFFFF, 16'hFFFF);
    send_beat(32'd1, 16'hFFFF, 16'h1234, 16'h0000);
    send_beat(32'hFFFF_FFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF);
    drain();
    st = 32'hFFFF_FFF0;  // envelope straddling the time wrap
    set_envelope(st, 16'd10, 16'd5, 16'd7, 16'd3);
    for (int t = -1; t <= 27; t += 2)
      send_beat(st + t, 16'hFFFF, 16'h8001, 16'h00FF);
    send_beat(st + 32'h7FFF_FFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF); // far future
    send_beat(st + 32'h8000_0000, 16'hFFFF, 16'hFFFF, 16'hFFFF); // far past
    drain();
    // Extremes: all lengths max, envelope longer than half the range is not
    // possible at 16 bits, so exercise max values and d at the bounds.
    set_envelope(32'h8000_0000, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF);
    send_beat(32'h8000_0000 + 32'hFFFE, 16'hFFFF, 16'hFFFF, 16'hFFFF);
    send_beat(32'h8000_0000 + 32'h1FFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF);
    send_beat(32'h8000_0000 + 32'h2FFFD, 16'hFFFF, 16'hFFFF, 16'hFFFF);
    send_beat(32'h8000_0000 + 32'h3FFFD, 16'hFFFF, 16'hFFFF, 16'hFFFF);
    drain();

    // Random: several envelope settings, ~700 beats in all.
    for (int ph = 0; ph < 10; ph++) begin
      // no idling at all on one phase
      idle_pct_in  = (ph == 3) ? 0 : 18;
      idle_pct_out = (ph == 3) ? 0 : 18;
      st = $urandom;
      a = ($urandom_range(3) == 0) ? 0 : $urandom_range(ph == 9 ? 65535 : 40);
      h = ($urandom_range(3) == 0) ? 0 : $urandom_range(ph == 9 ? 65535 : 20);
      r = ($urandom_range(3) == 0) ? 0 : $urandom_range(ph == 9 ? 65535 : 40);
      s = ($urandom_range(3) == 0) ? 0 : $urandom_range(ph == 9 ? 65535 : 20);
      set_envelope(st, 16'(a), 16'(h), 16'(r), 16'(s));
      if (ph == 5) begin
        fork
          begin
            hold_off = 1'b1;
            repeat (60) @(negedge clk_i);
            hold_off = 1'b0;
          end
        join_none
      end
      for (int i = 0; i < 70; i++)
        send_beat(rnd_now(st, a + h + r + s), rnd_chan(), rnd_chan(), rnd_chan());
      drain();
    end

    repeat (30) @(negedge clk_i);
    if (fail_cnt == 0 && pending == 0)
      $display("[attack_hold_release_envelope] OK");
    else
      $display("[attack_hold_release_envelope] ERROR");
    $finish;
  end
endmodule

>>> sim.f
src/ahre_pkg.sv
src/ahre_if.sv
src/ahre_front.sv
src/ahre_queue.sv
src/ahre_back.sv
src/attack_hold_release_envelope.sv
tb/ahre_checker.sv
tb/attack_hold_release_envelope_tb.sv
